### sv/assert_macros.svh
// Assertion macros used by the block's top-level RTL file.
// Included by the top level; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define JBDI_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("assertion failed");
`define JBDI_NEVER(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error("assertion failed");
`else
`define JBDI_ASSERT(lbl, clk, rst, prop)
`define JBDI_NEVER(lbl, clk, rst, expr)
`endif
`endif

### sv/jbdi_pkg.sv
// Types, constant tables and helper functions for the dequantize/IDCT block.
// No dependencies; used by the qtab, tokq, front, back and top-level files.
package jbdi_pkg;

  localparam int COEF_W  = 16;
  localparam int QUANT_W = 13;
  localparam int ROW_W   = 35;
  localparam int ACC_W   = 54;

  localparam logic [6:0] QUALITY_RESET = 7'd50;

  localparam logic [5:0] ZZ_TO_NAT [64] = '{
    6'd0,  6'd1,  6'd8,  6'd16, 6'd9,  6'd2,  6'd3,  6'd10,
    6'd17, 6'd24, 6'd32, 6'd25, 6'd18, 6'd11, 6'd4,  6'd5,
    6'd12, 6'd19, 6'd26, 6'd33, 6'd40, 6'd48, 6'd41, 6'd34,
    6'd27, 6'd20, 6'd13, 6'd6,  6'd7,  6'd14, 6'd21, 6'd28,
    6'd35, 6'd42, 6'd49, 6'd56, 6'd57, 6'd50, 6'd43, 6'd36,
    6'd29, 6'd22, 6'd15, 6'd23, 6'd30, 6'd37, 6'd44, 6'd51,
    6'd58, 6'd59, 6'd52, 6'd45, 6'd38, 6'd31, 6'd39, 6'd46,
    6'd53, 6'd60, 6'd61, 6'd54, 6'd47, 6'd55, 6'd62, 6'd63
  };

  localparam logic [6:0] BASE_QUANT [64] = '{
    7'd16, 7'd11, 7'd10, 7'd16, 7'd24,  7'd40,  7'd51,  7'd61,
    7'd12, 7'd12, 7'd14, 7'd19, 7'd26,  7'd58,  7'd60,  7'd55,
    7'd14, 7'd13, 7'd16, 7'd24, 7'd40,  7'd57,  7'd69,  7'd56,
    7'd14, 7'd17, 7'd22, 7'd29, 7'd51,  7'd87,  7'd80,  7'd62,
    7'd18, 7'd22, 7'd37, 7'd56, 7'd68,  7'd109, 7'd103, 7'd77,
    7'd24, 7'd35, 7'd55, 7'd64, 7'd81,  7'd104, 7'd113, 7'd92,
    7'd49, 7'd64, 7'd78, 7'd87, 7'd103, 7'd121, 7'd120, 7'd101,
    7'd72, 7'd92, 7'd95, 7'd98, 7'd112, 7'd100, 7'd103, 7'd99
  };

  localparam logic [14:0] COS_Q14 [9] = '{
    15'd16384, 15'd16069, 15'd15137, 15'd13623, 15'd11585,
    15'd9102,  15'd6270,  15'd3196,  15'd0
  };

  typedef enum logic [1:0] {Q_IDLE, Q_LOAD, Q_DIV, Q_STORE} qtab_state_t;
  typedef enum logic [1:0] {B_IDLE, B_ROW, B_COL} back_state_t;

  typedef struct packed {
    logic       en;
    logic [6:0] addr;
  } coef_rd_t;

  typedef struct packed {
    logic valid;
    logic bank;
  } tok_t;

  // alpha(u) * cos((2x+1) u pi / 16) in Q1.14
  function automatic logic signed [15:0] basis(input logic [2:0] x, input logic [2:0] u);
    logic [6:0] prod;
    logic [4:0] k;
    logic       neg;
    logic [15:0] mag;
    prod = 7'({x, 1'b1}) * 7'(u);
    k    = prod[4:0];
    neg  = 1'b0;
    if (k > 5'd16) k = 5'd0 - k;
    if (k > 5'd8) begin
      k   = 5'd16 - k;
      neg = 1'b1;
    end
    mag = 16'(COS_Q14[k[3:0]]);
    if (u == 3'd0) begin
      basis = 16'sd11585;
    end else begin
      basis = neg ? -$signed(mag) : $signed(mag);
    end
  endfunction

endpackage

### sv/jbdi_ifs.sv
// Handshake channel interfaces: coefficient input and pixel output.
// No dependencies.
interface jbdi_coef_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] coefficient;
  modport source (output valid, coefficient, input ready);
  modport sink (input valid, coefficient, output ready);
endinterface

interface jbdi_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel;
  logic       last_pixel;
  modport source (output valid, pixel, last_pixel, input ready);
  modport sink (input valid, pixel, last_pixel, output ready);
endinterface

### sv/jbdi_qtab.sv
// Quantizer table builder: one restoring divider fills a 64-entry table.
// Depends on jbdi_pkg.
module jbdi_qtab (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [6:0]  quality,
  input  logic [5:0]  rd_addr,
  output logic [12:0] rd_data,
  output logic        busy
);

  jbdi_pkg::qtab_state_t state, state_next;
  logic [5:0]  idx;
  logic [3:0]  step;
  logic [13:0] num;
  logic [6:0]  rem;
  logic [6:0]  den;
  logic        force_one;
  logic [12:0] mem [64];

  logic [6:0]  qe;
  logic [6:0]  b;
  logic [13:0] numer;
  logic [6:0]  denom;
  logic [7:0]  rs;
  logic        qb;
  logic [6:0]  rem_next;
  logic        wr_en;
  logic [12:0] wr_val;

  always_comb begin
    qe = (quality == 7'd0) ? 7'd1 : quality;
    b  = jbdi_pkg::BASE_QUANT[idx];
    if (qe < 7'd50) begin
      numer = 14'(b) * 14'd100 + 14'(qe);
      denom = {qe[5:0], 1'b0};
    end else begin
      numer = 14'(b) * 14'(7'd100 - qe) * 14'd2 + 14'd50;
      denom = 7'd100;
    end
    rs = {rem, num[13]};
    qb = rs >= {1'b0, den};
    rem_next = qb ? 7'(rs - {1'b0, den}) : rs[6:0];
  end

  always_comb begin
    state_next = state;
    case (state)
      jbdi_pkg::Q_IDLE:  state_next = jbdi_pkg::Q_IDLE;
      jbdi_pkg::Q_LOAD:  state_next = jbdi_pkg::Q_DIV;
      jbdi_pkg::Q_DIV:   if (step == 4'd13) state_next = jbdi_pkg::Q_STORE;
      jbdi_pkg::Q_STORE: if (idx == 6'd63) begin
        state_next = jbdi_pkg::Q_IDLE;
      end else begin
        state_next = jbdi_pkg::Q_LOAD;
      end
      default: state_next = jbdi_pkg::Q_IDLE;
    endcase
    if (start) state_next = jbdi_pkg::Q_LOAD;
  end

  always_comb begin
    busy   = state != jbdi_pkg::Q_IDLE;
    wr_en  = state == jbdi_pkg::Q_STORE;
    wr_val = (force_one || num == 14'd0) ? 13'd1 : num[12:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= jbdi_pkg::Q_LOAD;
      idx   <= '0;
    end else begin
      state <= state_next;
      if (start) begin
        idx <= '0;
      end else if (state == jbdi_pkg::Q_STORE) begin
        idx <= idx + 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      jbdi_pkg::Q_LOAD: begin
        num       <= numer;
        den       <= denom;
        rem       <= '0;
        step      <= '0;
        force_one <= qe >= 7'd100;
      end
      jbdi_pkg::Q_DIV: begin
        num  <= {num[12:0], qb};
        rem  <= rem_next;
        step <= step + 4'd1;
      end
      default: ;
    endcase
    if (wr_en) mem[idx] <= wr_val;
    rd_data <= mem[rd_addr];
  end

endmodule

### sv/jbdi_tokq.sv
// Two-entry queue of finished coefficient banks between front and back.
// Depends on jbdi_pkg.
module jbdi_tokq (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  logic           push_bank,
  input  logic           pop,
  output jbdi_pkg::tok_t head,
  output logic           full
);

  logic [1:0] count;
  logic       rptr, wptr;
  logic       ent [2];
  logic       do_push, do_pop;

  assign full    = count == 2'd2;
  assign do_push = push && !full;
  assign do_pop  = pop && count != 2'd0;
  assign head.valid = count != 2'd0;
  assign head.bank  = ent[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      rptr  <= 1'b0;
      wptr  <= 1'b0;
    end else begin
      if (do_push) wptr <= ~wptr;
      if (do_pop) rptr <= ~rptr;
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) ent[wptr] <= push_bank;
  end

endmodule

### sv/jbdi_front.sv
// Input side: takes coefficients, de-zigzags them into two coefficient banks.
// Depends on jbdi_pkg and jbdi_ifs.
module jbdi_front (
  input  logic                clk,
  input  logic                rst,
  jbdi_coef_if.sink           coef,
  input  logic                qbusy,
  input  logic                tok_full,
  output logic                tok_push,
  output logic                tok_bank,
  input  jbdi_pkg::coef_rd_t  rd_req,
  output logic signed [15:0]  rd_data
);

  logic [5:0]         cnt;
  logic               wbank;
  logic               accept;
  logic signed [15:0] mem [128];

  assign coef.ready = !tok_full && !qbusy;
  assign accept     = coef.valid && coef.ready;
  assign tok_push   = accept && cnt == 6'd63;
  assign tok_bank   = wbank;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt   <= '0;
      wbank <= 1'b0;
    end else if (accept) begin
      cnt <= cnt + 6'd1;
      if (cnt == 6'd63) wbank <= ~wbank;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) mem[{wbank, jbdi_pkg::ZZ_TO_NAT[cnt]}] <= coef.coefficient;
    if (rd_req.en) rd_data <= mem[rd_req.addr];
  end

endmodule

### sv/jbdi_back.sv
// Transform side: dequantize, row pass, column pass on one shared MAC,
// rounding/clamp and a four-entry pixel buffer. Depends on jbdi_pkg, jbdi_ifs.
module jbdi_back (
  input  logic                clk,
  input  logic                rst,
  input  jbdi_pkg::tok_t      tok,
  output logic                tok_pop,
  output jbdi_pkg::coef_rd_t  coef_rd,
  input  logic signed [15:0]  coef_data,
  output logic [5:0]          quant_addr,
  input  logic [12:0]         quant_data,
  jbdi_pix_if.source          pix
);

  typedef struct packed {
    logic       valid;
    logic       col;
    logic       first;
    logic       last;
    logic       lastpix;
    logic [5:0] waddr;
  } tag_t;

  jbdi_pkg::back_state_t state, state_next;
  logic [8:0] cnt;
  logic [2:0] ca, cj, ck;
  logic       bank;
  logic       issue;
  logic       col;
  logic [2:0] fcnt;
  logic [2:0] pending;

  tag_t b_tag, c_tag, d_tag;
  logic signed [15:0] b_basis, c_basis;
  logic signed [34:0] c_opnd;
  logic signed [50:0] d_prod;
  logic signed [53:0] acc, sum;
  logic               e_valid, e_last;
  logic signed [53:0] e_sum;

  logic signed [34:0] rs_mem [64];
  logic signed [34:0] rs_data;
  logic signed [29:0] dq;
  logic signed [15:0] dq16;

  logic        neg;
  logic [53:0] mag, madd;
  logic [23:0] mr;
  logic signed [25:0] r;
  logic [7:0]  pix_val;

  logic [7:0]  fpix [4];
  logic        flast [4];
  logic [1:0]  frptr, fwptr;
  logic        fpop;

  assign ca  = cnt[8:6];
  assign cj  = cnt[5:3];
  assign ck  = cnt[2:0];
  assign col = state == jbdi_pkg::B_COL;

  always_comb begin
    state_next = state;
    case (state)
      jbdi_pkg::B_IDLE: if (tok.valid) state_next = jbdi_pkg::B_ROW;
      jbdi_pkg::B_ROW:  if (cnt == 9'd511) state_next = jbdi_pkg::B_COL;
      jbdi_pkg::B_COL:  if (issue && cnt == 9'd511) state_next = jbdi_pkg::B_IDLE;
      default:          state_next = jbdi_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    issue   = 1'b0;
    tok_pop = 1'b0;
    case (state)
      jbdi_pkg::B_ROW: begin
        issue   = 1'b1;
        tok_pop = cnt == 9'd511;
      end
      jbdi_pkg::B_COL: issue = (ck != 3'd0) || ({1'b0, fcnt} + {1'b0, pending} < 4'd4);
      default: ;
    endcase
    coef_rd.en   = issue && state == jbdi_pkg::B_ROW;
    coef_rd.addr = {bank, ca, ck};
    quant_addr   = {ca, ck};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= jbdi_pkg::B_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (state == jbdi_pkg::B_IDLE) begin
        cnt <= '0;
      end else if (issue) begin
        cnt <= cnt + 9'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == jbdi_pkg::B_IDLE && tok.valid) bank <= tok.bank;
  end

  // MAC pipeline
  always_comb begin
    dq   = coef_data * $signed({1'b0, quant_data});
    dq16 = dq[15:0];
    sum  = d_tag.first ? 54'(d_prod) : acc + 54'(d_prod);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_tag   <= '0;
      c_tag   <= '0;
      d_tag   <= '0;
      e_valid <= 1'b0;
    end else begin
      b_tag.valid   <= issue;
      b_tag.col     <= col;
      b_tag.first   <= ck == 3'd0;
      b_tag.last    <= ck == 3'd7;
      b_tag.lastpix <= col && cnt == 9'd511;
      b_tag.waddr   <= {ca, cj};
      c_tag         <= b_tag;
      d_tag         <= c_tag;
      e_valid       <= d_tag.valid && d_tag.last && d_tag.col;
    end
  end

  always_ff @(posedge clk) begin
    b_basis <= col ? jbdi_pkg::basis(ca, ck) : jbdi_pkg::basis(cj, ck);
    rs_data <= rs_mem[{ck, cj}];
    c_basis <= b_basis;
    c_opnd  <= b_tag.col ? rs_data : 35'(dq16);
    d_prod  <= c_opnd * c_basis;
    if (d_tag.valid) acc <= sum;
    if (d_tag.valid && d_tag.last && !d_tag.col) rs_mem[d_tag.waddr] <= sum[34:0];
    e_sum  <= sum;
    e_last <= d_tag.lastpix;
  end

  // divide by 2^30 rounding half away, offset, clamp
  always_comb begin
    neg  = e_sum[53];
    mag  = neg ? 54'(-e_sum) : 54'(e_sum);
    madd = mag + (54'd1 << 29);
    mr   = madd[53:30];
    r    = neg ? -$signed({2'b00, mr}) : $signed({2'b00, mr});
    r    = r + 26'sd128;
    if (r < 26'sd0) begin
      pix_val = 8'd0;
    end else if (r > 26'sd255) begin
      pix_val = 8'd255;
    end else begin
      pix_val = r[7:0];
    end
  end

  // pixel buffer
  assign fpop           = pix.valid && pix.ready;
  assign pix.valid      = fcnt != 3'd0;
  assign pix.pixel      = fpix[frptr];
  assign pix.last_pixel = flast[frptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      fcnt    <= '0;
      frptr   <= '0;
      fwptr   <= '0;
      pending <= '0;
    end else begin
      if (e_valid) fwptr <= fwptr + 2'd1;
      if (fpop) frptr <= frptr + 2'd1;
      fcnt    <= fcnt + 3'(e_valid) - 3'(fpop);
      pending <= pending + 3'(issue && col && ck == 3'd0) - 3'(e_valid);
    end
  end

  always_ff @(posedge clk) begin
    if (e_valid) begin
      fpix[fwptr]  <= pix_val;
      flast[fwptr] <= e_last;
    end
  end

endmodule

### sv/jpeg_block_dequant_idct.sv
// 8x8 JPEG block dequantizer and integer IDCT, one MAC shared by both passes.
// Each block takes 512 row and 512 column multiply-accumulates through the
// single MAC; the column pass stalls when the four-entry pixel buffer has no
// room. The input side can take the next block while the last is transformed.
// Reset (synchronous, rst high): quality 50; the quantizer table is rebuilt
// after reset and after each quality write, input held off meanwhile.
`include "assert_macros.svh"
module jpeg_block_dequant_idct (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  jbdi_coef_if.sink   coef_in,
  jbdi_pix_if.source  pix_out
);

  logic [6:0]         quality;
  logic               quality_wr;
  logic               qbusy;
  logic [5:0]         quant_addr;
  logic [12:0]        quant_data;
  logic               tok_push, tok_bank, tok_pop, tok_full;
  jbdi_pkg::tok_t     tok_head;
  jbdi_pkg::coef_rd_t coef_rd;
  logic signed [15:0] coef_data;

  assign pready     = 1'b1;
  assign quality_wr = psel && penable && pwrite && !paddr[2];
  assign prdata     = paddr[2] ? 32'd0 : 32'(quality);

  always_ff @(posedge clk) begin
    if (rst) begin
      quality <= jbdi_pkg::QUALITY_RESET;
    end else if (quality_wr) begin
      quality <= pwdata[6:0];
    end
  end

  jbdi_qtab u_qtab (
    .clk     (clk),
    .rst     (rst),
    .start   (quality_wr),
    .quality (quality),
    .rd_addr (quant_addr),
    .rd_data (quant_data),
    .busy    (qbusy)
  );

  jbdi_front u_front (
    .clk      (clk),
    .rst      (rst),
    .coef     (coef_in),
    .qbusy    (qbusy),
    .tok_full (tok_full),
    .tok_push (tok_push),
    .tok_bank (tok_bank),
    .rd_req   (coef_rd),
    .rd_data  (coef_data)
  );

  jbdi_tokq u_tokq (
    .clk       (clk),
    .rst       (rst),
    .push      (tok_push),
    .push_bank (tok_bank),
    .pop       (tok_pop),
    .head      (tok_head),
    .full      (tok_full)
  );

  jbdi_back u_back (
    .clk        (clk),
    .rst        (rst),
    .tok        (tok_head),
    .tok_pop    (tok_pop),
    .coef_rd    (coef_rd),
    .coef_data  (coef_data),
    .quant_addr (quant_addr),
    .quant_data (quant_data),
    .pix        (pix_out)
  );

  `JBDI_NEVER(a_no_transfer_while_qtab, clk, rst, coef_in.valid && coef_in.ready && qbusy)
  `JBDI_NEVER(a_no_pop_empty, clk, rst, tok_pop && !tok_head.valid)
  `JBDI_NEVER(a_no_push_full, clk, rst, tok_push && tok_full)
  `JBDI_ASSERT(a_qtab_restart, clk, rst, quality_wr |=> qbusy)

endmodule
